/* sv/bss_pkg.sv */
`timescale 1ns / 1ps
// Package for the byte substring search block: widths, register codes,
// default parameter values and the control bundle handed to each cell.
// No dependencies.
package bss_pkg;

    // Default values for the top-level parameters
    localparam int NEEDLE_MAX_DEF   = 16;
    localparam int OFFSET_WIDTH_DEF = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int NLEN_W     = 5;

    // Stream payload widths
    localparam int S_TDATA_W    = 8;
    localparam int OUT_OFFSET_W = 16;
    localparam int M_TDATA_W    = 24;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LOW  = 2'd0,
        REG_NEEDLE_HIGH = 2'd1,
        REG_NEEDLE_LEN  = 2'd2
    } bss_reg_idx_t;

    // Per-cell control: shift strobe, position in use, aligned needle byte
    typedef struct packed {
        logic       shift_en;
        logic       active;
        logic [7:0] needle_byte;
    } bss_cell_ctrl_t;

endpackage

/* sv/bss_cell.sv */
`timescale 1ns / 1ps
// One history cell: holds one haystack byte, passes it on to the next cell
// and compares its incoming byte with the needle byte aligned to it.
// Depends on bss_pkg.
module bss_cell (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  bss_pkg::bss_cell_ctrl_t ctrl,
    input  logic [7:0]              byte_in,
    output logic [7:0]              byte_out,
    output logic                    hit
);
    import bss_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // shift in the neighbor's byte when a byte is taken within the offset range
    always_comb begin
        byte_next = ctrl.shift_en ? byte_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= '0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    // compare the value this cell holds after the shift
    assign hit      = !ctrl.active || (byte_in == ctrl.needle_byte);
    assign byte_out = byte_reg;

endmodule

/* sv/byte_substring_search.sv */
`timescale 1ns / 1ps
// Top level of the streaming byte substring search: configuration registers,
// the row of history cells, haystack bookkeeping and the result register.
// Depends on bss_pkg and bss_cell.
//
//  channel   direction  payload                                   marks
//  s_        in         tdata: data_byte  tuser: first_flag        tlast: last_flag
//  m_        out        tdata: found, match_offset, overflow       -
//  cfg_      in         index 0 needle low, 1 needle high, 2 len   write only
//
// One byte is taken every cycle unless a held result stalls the input; all needle
// positions are compared at once across the cell row, so the rate is one byte per clock.
// A result is loaded into the output register on the edge that takes a
// last byte and is visible on the next cycle.
// s_tready drops only while a result is held and m_tready is low.
// Synchronous active-low reset clears the needle to length 1 and all state but the result data.
module byte_substring_search #(
    parameter int NEEDLE_MAX   = bss_pkg::NEEDLE_MAX_DEF,
    parameter int OFFSET_WIDTH = bss_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [bss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bss_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // haystack input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bss_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                            s_tuser,   // [0] first_flag
    input  logic                            s_tlast,   // last_flag
    // result output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bss_pkg::M_TDATA_W-1:0]   m_tdata    // [0] found, [16:1] match_offset,
                                                       // [17] overflow, [23:18] zero
);
    import bss_pkg::*;

    localparam int LEN_W = $clog2(NEEDLE_MAX + 1);
    localparam int CNT_W = OFFSET_WIDTH + 1;

    // configuration registers
    logic [CFG_DATA_W-1:0] cfg_low_reg;
    logic [CFG_DATA_W-1:0] cfg_high_reg;
    logic [NLEN_W-1:0]     cfg_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_low_reg  <= '0;
            cfg_high_reg <= '0;
            cfg_len_reg  <= NLEN_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NEEDLE_LOW:  cfg_low_reg  <= cfg_wdata;
                REG_NEEDLE_HIGH: cfg_high_reg <= cfg_wdata;
                REG_NEEDLE_LEN:  cfg_len_reg  <= cfg_wdata[NLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // effective needle length, saturated to the row length
    logic [LEN_W-1:0] len;
    always_comb begin
        if (int'(cfg_len_reg) > NEEDLE_MAX) begin
            len = LEN_W'(NEEDLE_MAX);
        end else begin
            len = LEN_W'(cfg_len_reg);
        end
    end

    // needle bytes by position; positions 16 and up read as zero
    logic [7:0] needle [NEEDLE_MAX];
    for (genvar p = 0; p < NEEDLE_MAX; p++) begin : g_needle
        if (p < 8) begin : g_low
            assign needle[p] = cfg_low_reg[8*p +: 8];
        end else if (p < 16) begin : g_high
            assign needle[p] = cfg_high_reg[8*(p-8) +: 8];
        end else begin : g_zero
            assign needle[p] = 8'h00;
        end
    end

    // handshakes
    logic m_valid_reg;
    logic in_acc;
    logic out_acc;
    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_valid_reg && m_tready;

    // haystack state
    logic [CNT_W-1:0]        count_reg,     count_next;
    logic                    seen_reg,      seen_next;
    logic [OFFSET_WIDTH-1:0] first_off_reg, first_off_next;
    logic                    ovf_reg,       ovf_next;

    // state as seen by this byte: a first flag clears it beforehand
    logic [CNT_W-1:0]        eff_count;
    logic                    eff_seen;
    logic [OFFSET_WIDTH-1:0] eff_off;
    logic                    eff_ovf;
    logic                    take_byte;

    assign eff_count = s_tuser ? '0   : count_reg;
    assign eff_seen  = s_tuser ? 1'b0 : seen_reg;
    assign eff_off   = s_tuser ? '0   : first_off_reg;
    assign eff_ovf   = s_tuser ? 1'b0 : ovf_reg;
    // count stops once the offset range is used up
    assign take_byte = in_acc && !eff_ovf && !eff_count[CNT_W-1];

    // cell row
    bss_cell_ctrl_t    ctrl [NEEDLE_MAX];
    logic [7:0]        hist [NEEDLE_MAX];
    logic [NEEDLE_MAX-1:0] hit_vec;

    for (genvar j = 0; j < NEEDLE_MAX; j++) begin : g_cell
        logic [7:0] nb;
        logic [7:0] cell_in;

        // needle byte that lines up with this history slot
        always_comb begin
            nb = 8'h00;
            for (int p = 0; p < NEEDLE_MAX; p++) begin
                if (p + j + 1 == int'(len)) begin
                    nb = needle[p];
                end
            end
        end

        assign ctrl[j].shift_en    = take_byte;
        assign ctrl[j].active      = (j < int'(len));
        assign ctrl[j].needle_byte = nb;

        if (j == 0) begin : g_head
            assign cell_in = s_tdata[7:0];
        end else begin : g_link
            assign cell_in = hist[j-1];
        end

        bss_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl[j]),
            .byte_in  (cell_in),
            .byte_out (hist[j]),
            .hit      (hit_vec[j])
        );
    end

    // match detection and state update
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] len_ext;
    logic [CNT_W-1:0] start_pos;
    logic             new_match;

    assign count_inc = eff_count + CNT_W'(1);
    assign len_ext   = CNT_W'(len);
    assign start_pos = count_inc - len_ext;
    assign new_match = take_byte && (len != '0) && !eff_seen
                       && (count_inc >= len_ext) && (&hit_vec);

    always_comb begin
        count_next     = count_reg;
        seen_next      = seen_reg;
        first_off_next = first_off_reg;
        ovf_next       = ovf_reg;
        if (in_acc) begin
            count_next     = take_byte ? count_inc : eff_count;
            seen_next      = eff_seen || new_match;
            first_off_next = new_match ? start_pos[OFFSET_WIDTH-1:0] : eff_off;
            ovf_next       = !take_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            first_off_reg <= '0;
            ovf_reg       <= 1'b0;
        end else if (in_acc && s_tlast) begin
            // result leaves; next byte starts a fresh haystack
            count_reg     <= '0;
            seen_reg      <= 1'b0;
            first_off_reg <= '0;
            ovf_reg       <= 1'b0;
        end else begin
            count_reg     <= count_next;
            seen_reg      <= seen_next;
            first_off_reg <= first_off_next;
            ovf_reg       <= ovf_next;
        end
    end

    // result register
    logic                    found_reg,  found_next;
    logic [OUT_OFFSET_W-1:0] offset_reg, offset_next;
    logic                    rovf_reg;
    logic                    m_valid_next;
    logic [31:0]             off_wide;

    assign off_wide = 32'(first_off_next);

    always_comb begin
        // empty needle always matches at the start
        if (len == '0) begin
            found_next  = 1'b1;
            offset_next = '0;
        end else begin
            found_next  = seen_next;
            offset_next = seen_next ? off_wide[OUT_OFFSET_W-1:0] : '0;
        end

        m_valid_next = m_valid_reg;
        if (in_acc && s_tlast) begin
            m_valid_next = 1'b1;
        end else if (out_acc) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc && s_tlast) begin
            found_reg  <= found_next;
            offset_reg <= offset_next;
            rovf_reg   <= ovf_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_OFFSET_W - 2){1'b0}},
                       rovf_reg, offset_reg, found_reg};

endmodule

/* sv/bss_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the byte substring search top level, with the bind
// that attaches them. Depends on bss_pkg and byte_substring_search.
module bss_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bss_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bss_pkg::*;

    // a held result does not change while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

    // a last byte taken always yields a result on the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("no result after last byte");

    // no result appears without a last byte taken just before
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without a last byte");

    // input is open whenever no result is held
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // no match means a zero offset
    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[OUT_OFFSET_W:1] == '0))
        else $error("offset set without a match");

endmodule

bind byte_substring_search bss_checker u_bss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/substring_match_monitor.sv */
`timescale 1ns / 1ps
// Monitor for the byte substring search testbench: follows register writes and
// both streams, predicts each search report and compares it when it is taken.
// Depends on bss_pkg.
module substring_match_monitor
    import bss_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] first_flag
    input  logic                  s_tlast,   // last_flag
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // [0] found, [16:1] match_offset, [17] overflow
    output int                    mismatches,
    output int                    reports_due
);

    localparam int HIST_DEPTH  = NEEDLE_MAX_DEF;
    localparam int COUNT_LIMIT = 1 << OFFSET_WIDTH_DEF;

    typedef struct packed {
        logic                    overflow;
        logic [OUT_OFFSET_W-1:0] offset;
        logic                    found;
    } search_report_t;

    // needle registers as last written
    logic [63:0]       needle_lo;
    logic [63:0]       needle_hi;
    logic [NLEN_W-1:0] needle_len;

    // per-haystack tracking
    logic [7:0]              history [HIST_DEPTH];
    int                      byte_cnt;
    logic                    match_hit;
    logic [OUT_OFFSET_W-1:0] match_pos;
    logic                    range_over;

    search_report_t report_q [$];

    function automatic logic [7:0] needle_at(input int pos);
        if (pos < 8) begin
            return needle_lo[8*pos +: 8];
        end
        if (pos < 16) begin
            return needle_hi[8*(pos-8) +: 8];
        end
        return 8'h00;
    endfunction

    task automatic clear_run();
        byte_cnt   = 0;
        match_hit  = 1'b0;
        match_pos  = '0;
        range_over = 1'b0;
    endtask

    // Advance the search by one haystack byte; queue a report on the last byte
    task automatic take_byte(input logic [7:0] data, input logic first, input logic last);
        int             len;
        int             i;
        logic           same;
        search_report_t rep;
        len = (needle_len > HIST_DEPTH) ? HIST_DEPTH : int'(needle_len);
        if (first) begin
            clear_run();
        end
        if (range_over || byte_cnt >= COUNT_LIMIT) begin
            // counting, shifting and matching freeze once the range is passed
            range_over = 1'b1;
        end else begin
            for (i = HIST_DEPTH - 1; i > 0; i--) begin
                history[i] = history[i-1];
            end
            history[0] = data;
            byte_cnt++;
            if (len > 0 && !match_hit && byte_cnt >= len) begin
                same = 1'b1;
                for (i = 0; i < len; i++) begin
                    if (history[len-1-i] != needle_at(i)) begin
                        same = 1'b0;
                    end
                end
                if (same) begin
                    match_hit = 1'b1;
                    match_pos = OUT_OFFSET_W'(byte_cnt - len);
                end
            end
        end
        if (last) begin
            // empty needle always matches at the start
            rep.found    = (len == 0) ? 1'b1 : match_hit;
            rep.offset   = (len == 0 || !match_hit) ? '0 : match_pos;
            rep.overflow = range_over;
            report_q.push_back(rep);
            clear_run();
        end
    endtask

    always @(posedge aclk) begin
        search_report_t want;
        int             k;
        if (!aresetn) begin
            needle_lo  = '0;
            needle_hi  = '0;
            needle_len = NLEN_W'(1);
            for (k = 0; k < HIST_DEPTH; k++) begin
                history[k] = 8'h00;
            end
            clear_run();
            report_q.delete();
        end else begin
            // reports leaving the block
            if (m_tvalid && m_tready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected report, expected none, got found=%0d offset=%0d overflow=%0d",
                             $time, m_tdata[0], m_tdata[OUT_OFFSET_W:1], m_tdata[OUT_OFFSET_W+1]);
                    mismatches++;
                end else begin
                    want = report_q.pop_front();
                    if (m_tdata[0] !== want.found) begin
                        $display("%0t: found expected %0d got %0d", $time, want.found, m_tdata[0]);
                        mismatches++;
                    end
                    if (m_tdata[OUT_OFFSET_W:1] !== want.offset) begin
                        $display("%0t: match_offset expected %0d got %0d",
                                 $time, want.offset, m_tdata[OUT_OFFSET_W:1]);
                        mismatches++;
                    end
                    if (m_tdata[OUT_OFFSET_W+1] !== want.overflow) begin
                        $display("%0t: overflow expected %0d got %0d",
                                 $time, want.overflow, m_tdata[OUT_OFFSET_W+1]);
                        mismatches++;
                    end
                    if (m_tdata[M_TDATA_W-1:OUT_OFFSET_W+2] !== '0) begin
                        $display("%0t: tdata padding expected 0 got %0h",
                                 $time, m_tdata[M_TDATA_W-1:OUT_OFFSET_W+2]);
                        mismatches++;
                    end
                end
            end
            // register writes
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_NEEDLE_LOW: begin
                        needle_lo = cfg_wdata;
                    end
                    REG_NEEDLE_HIGH: begin
                        needle_hi = cfg_wdata;
                    end
                    REG_NEEDLE_LEN: begin
                        needle_len = cfg_wdata[NLEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // haystack requests entering the block
            if (s_tvalid && s_tready) begin
                take_byte(s_tdata, s_tuser, s_tlast);
            end
        end
        reports_due = report_q.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top for byte_substring_search: clock, reset, needle setup, haystack
// stimulus and verdict. Depends on bss_pkg, byte_substring_search, substring_match_monitor.
module tb_top;
    import bss_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] data_byte
    logic                  s_tuser   = 1'b0; // [0] first_flag
    logic                  s_tlast   = 1'b0; // last_flag
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [0] found, [16:1] match_offset, [17] overflow

    int mismatches;
    int reports_due;

    // stimulus state
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    int           bytes_sent     = 0;
    logic [127:0] cur_needle     = '0;
    int           cur_len        = 1;

    always #5 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    byte_substring_search dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    substring_match_monitor monitor (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    // One haystack request; returns at the edge that accepts it
    task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
        logic ready_seen;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        s_tlast  <= last;
        // ready is stable between the falling and the next rising edge
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        bytes_sent++;
    endtask

    // Stop sending until every predicted report has come out
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do begin
            @(negedge aclk);
        end while (reports_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_needle(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [NLEN_W-1:0] len);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_NEEDLE_LOW;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_index <= REG_NEEDLE_HIGH;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= REG_NEEDLE_LEN;
        cfg_wdata <= CFG_DATA_W'(len);
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        cur_needle = {hi, lo};
        cur_len    = (len > NEEDLE_MAX_DEF) ? NEEDLE_MAX_DEF : int'(len);
    endtask

    // Random haystack, mostly well framed, biased toward needle bytes
    task automatic random_haystack();
        logic [7:0] text [$];
        int         n;
        int         at;
        int         pos;
        int         i;
        logic       first;
        logic       last;
        bit         tidy;
        n = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
        for (i = 0; i < n; i++) begin
            if (cur_len > 0 && $urandom_range(1) == 1) begin
                pos = $urandom_range(cur_len - 1);
                text.push_back(cur_needle[8*pos +: 8]);
            end else begin
                text.push_back(8'($urandom));
            end
        end
        // plant a full copy of the needle somewhere
        if (cur_len > 0 && cur_len <= n && $urandom_range(1) == 1) begin
            at = $urandom_range(n - cur_len);
            for (i = 0; i < cur_len; i++) begin
                text[at+i] = cur_needle[8*i +: 8];
            end
        end
        tidy = ($urandom_range(99) < 85);
        for (i = 0; i < n; i++) begin
            if (tidy) begin
                first = (i == 0);
                last  = (i == n - 1);
            end else begin
                first = ($urandom_range(9) == 0);
                last  = ($urandom_range(11) == 0) || (i == n - 1 && $urandom_range(1) == 1);
            end
            send_byte(text[i], first, last);
        end
    endtask

    // Run limit
    initial begin
        #10_000_000;
        $display("FAIL byte_substring_search");
        $finish;
    end

    initial begin
        int                phase;
        int                phase_start;
        int                i;
        int                r;
        logic [NLEN_W-1:0] len;
        logic [63:0]       lo;
        logic [63:0]       hi;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset needle is a single zero byte
        send_byte(8'h00, 1'b1, 1'b1);

        // needle "AB": match ending on the final byte
        wait_idle();
        load_needle(64'h4241, 64'h0, NLEN_W'(2));
        send_byte(8'h78, 1'b1, 1'b0);
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b1);
        // first flag mid-stream restarts the offset count
        send_byte(8'h41, 1'b1, 1'b0);
        send_byte(8'h78, 1'b1, 1'b0);
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b1);
        // restart splits the needle; one-byte haystack is shorter than the needle
        send_byte(8'h41, 1'b1, 1'b0);
        send_byte(8'h42, 1'b1, 1'b1);
        // no first flag after a last byte still opens a new haystack
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b1);

        // empty needle
        wait_idle();
        load_needle('1, '1, NLEN_W'(0));
        send_byte(8'hFF, 1'b1, 1'b1);

        // oversize length saturates to the full 16 bytes
        wait_idle();
        load_needle(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, NLEN_W'(31));
        send_byte(8'h5A, 1'b1, 1'b0);
        for (i = 0; i < 16; i++) begin
            send_byte(cur_needle[8*i +: 8], 1'b0, i == 15);
        end

        // random phases: no idling, sender idle, receiver stalling, both
        for (phase = 0; phase < 4; phase++) begin
            wait_idle();
            send_idle_pct  = (phase == 1) ? 69 : (phase == 3) ? 15 : 0;
            recv_stall_pct = (phase == 2) ? 69 : (phase == 3) ? 15 : 0;
            phase_start    = bytes_sent;
            while (bytes_sent < phase_start + PHASE_ITEMS) begin
                if (bytes_sent == phase_start || $urandom_range(4) == 0) begin
                    wait_idle();
                    r = $urandom_range(99);
                    if (r < 8) begin
                        len = NLEN_W'(0);
                    end else if (r < 70) begin
                        len = NLEN_W'($urandom_range(1, 4));
                    end else if (r < 88) begin
                        len = NLEN_W'($urandom_range(5, 16));
                    end else begin
                        len = NLEN_W'($urandom_range(17, 31));
                    end
                    case ($urandom_range(7))
                        0: lo = '0;
                        1: lo = '1;
                        default: lo = {$urandom, $urandom};
                    endcase
                    case ($urandom_range(7))
                        0: hi = '0;
                        1: hi = '1;
                        default: hi = {$urandom, $urandom};
                    endcase
                    load_needle(lo, hi, len);
                end
                random_haystack();
            end
        end

        wait_idle();
        @(negedge aclk);
        if (mismatches == 0 && reports_due == 0) begin
            $display("PASS byte_substring_search");
        end else begin
            $display("FAIL byte_substring_search");
        end
        $finish;
    end

endmodule
